### src/assert_macros.svh
// Assertion macros shared by the bit vector engine modules.
// Users must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is held.
`define BVE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define BVE_ASSERT_NEXT(lbl, ante, cons, msg) \
    `BVE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### src/bve_pkg.sv
// Package for the bit vector engine: sizes, opcodes, FSM state, control structs
// and word helper functions. No dependencies.
package bve_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS = 32;
    localparam int WB_LOG    = $clog2(WORD_BITS);
    localparam int WIDX_W    = $clog2(MAX_WORDS);
    localparam int MAX_BITS  = WORD_BITS * MAX_WORDS;
    localparam int LEN_W     = 11;
    localparam int BIDX_W    = 10;
    localparam int CNT_W     = 11;
    localparam int OP_W      = 4;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WIDX_W-1:0]    t_widx;
    typedef logic [LEN_W-1:0]     t_len;

    typedef enum logic [OP_W-1:0] {
        OP_TEST       = 4'd0,
        OP_TEST_SET   = 4'd1,
        OP_TEST_CLEAR = 4'd2,
        OP_NEXT_SET   = 4'd3,
        OP_COUNT      = 4'd4,
        OP_ALL_CLEAR  = 4'd5,
        OP_SET_ALL    = 4'd6,
        OP_CLEAR_ALL  = 4'd7,
        OP_COMPLEMENT = 4'd8,
        OP_OR         = 4'd9,
        OP_AND        = 4'd10,
        OP_MINUS      = 4'd11,
        OP_OR_NOT     = 4'd12,
        OP_READ_WORD  = 4'd13
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic latch;   // capture input word
        logic start;   // decode, single-word ops, sweep setup
        logic step;    // one word of a sweep
        logic emit;    // load output register
    } t_dp_cmd;

    typedef struct packed {
        logic sweep;   // current op walks the words
        logic done;    // sweep ends this cycle
    } t_dp_sts;

    // Index of the highest word in use.
    function automatic t_widx last_word(input t_len len);
        t_len m1;
        m1 = len - LEN_W'(1);
        return m1[WB_LOG +: WIDX_W];
    endfunction

    // Bits of word k that lie below the length.
    function automatic t_word word_mask(input t_len len, input t_widx k);
        t_widx             lw;
        logic [WB_LOG-1:0] off;
        t_word             m;
        lw  = last_word(len);
        off = len[WB_LOG-1:0];
        if (k < lw) begin
            m = '1;
        end else if (k == lw) begin
            m = (off == '0) ? '1 : ~(t_word'('1) << off);
        end else begin
            m = '0;
        end
        return m;
    endfunction

    function automatic logic [WB_LOG:0] pop_word(input t_word w);
        logic [WB_LOG:0] c;
        c = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            c = c + (WB_LOG+1)'(w[i]);
        end
        return c;
    endfunction

    // Position of the lowest set bit (0 when none).
    function automatic logic [WB_LOG-1:0] low_bit(input t_word w);
        logic [WB_LOG-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                p = WB_LOG'(i);
            end
        end
        return p;
    endfunction

    // Zero reads as one, anything above capacity saturates.
    function automatic t_len sat_len(input t_len v);
        t_len r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_BITS)) begin
            r = LEN_W'(MAX_BITS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### src/bit_vector_engine_unit.sv
// Top level of the bit vector engine: controller plus datapath.
// Depends on bve_pkg, bve_ctrl and bve_datapath.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one command word (opcode,
//   bit index, word index, operand word); output channel o_out_valid/
//   i_out_ready returns exactly one result word per command.
//   i_cfg_we/i_cfg_wdata writes the bit length (0 reads as 1, values above
//   1024 saturate); bits at or above the new length are cleared in that cycle.
//   Write the length only while no command is in flight.
//   Steps: test/set/clear, word ops and errors go from accept through the
//   execute and finish states to the output register; count, all-clear and
//   whole-vector ops sweep the W words in use (up to 32 at full length) in
//   between; next-set sweeps from start word p to a hit or the last word.
//   The shared word port visits one word per cycle. One command is worked at
//   a time; the next is taken once the last result is in the output register.
//   A finished result sits in the output register; the next command is taken
//   and executed meanwhile and waits for the slot when the receiver stalls.
//   Reset (synchronous, active low) clears every stored bit, sets length to
//   1024 and empties the output register.
module bit_vector_engine_unit
    import bve_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [BIDX_W-1:0] i_bit_index,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [31:0]       i_operand_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_old_bit,
    output logic              o_found,
    output logic [BIDX_W-1:0] o_found_index,
    output logic [CNT_W-1:0]  o_bit_count,
    output logic              o_all_clear,
    output logic [31:0]       o_word_out,
    output logic              o_index_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bve_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_bit_index    (i_bit_index),
        .i_word_index   (i_word_index),
        .i_operand_word (i_operand_word),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_old_bit      (o_old_bit),
        .o_found        (o_found),
        .o_found_index  (o_found_index),
        .o_bit_count    (o_bit_count),
        .o_all_clear    (o_all_clear),
        .o_word_out     (o_word_out),
        .o_index_error  (o_index_error)
    );

endmodule

### src/bve_ctrl.sv
// Controller FSM of the bit vector engine: input/output handshakes and
// sequencing of the datapath. Depends on bve_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bve_ctrl
    import bve_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.sweep ? S_SWEEP : S_FIN;
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (i_sts.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // output slot free or being drained this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `BVE_ASSERT_NEXT(a_accept_exec, i_in_valid && o_in_ready, r_state == S_EXEC,
        "accepted word did not move to execute")
    `BVE_ASSERT_NEXT(a_stall_hold, r_state == S_FIN && r_out_valid && !i_out_ready,
        r_state == S_FIN && r_out_valid, "pending result dropped under stall")
    `BVE_ASSERT_NEXT(a_sweep_end, r_state == S_SWEEP && i_sts.done, r_state == S_FIN,
        "sweep did not end on done")
    `BVE_ASSERT_NEXT(a_single_op, r_state == S_EXEC && !i_sts.sweep, r_state == S_FIN,
        "single-word op entered sweep")

endmodule

### src/bve_datapath.sv
// Datapath of the bit vector engine: word store, length register, sweep unit
// (count, search, whole-vector ops) and output register.
// Depends on bve_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bve_datapath
    import bve_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [BIDX_W-1:0] i_bit_index,
    input  logic [WIDX_W-1:0] i_word_index,
    input  logic [31:0]       i_operand_word,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    output logic              o_old_bit,
    output logic              o_found,
    output logic [BIDX_W-1:0] o_found_index,
    output logic [CNT_W-1:0]  o_bit_count,
    output logic              o_all_clear,
    output logic [31:0]       o_word_out,
    output logic              o_index_error
);

    t_word             r_words [MAX_WORDS];
    t_len              r_len, n_len;
    t_opcode           r_op;
    logic [BIDX_W-1:0] r_bi;
    t_widx             r_wi;
    t_word             r_opw;
    t_widx             r_k, n_k;
    logic              r_first, n_first;
    logic              r_old, n_old;
    logic              r_found, n_found;
    logic [BIDX_W-1:0] r_fidx, n_fidx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_allc, n_allc;
    t_word             r_wout, n_wout;
    logic              r_err, n_err;

    t_widx             pos, lw, rd_idx;
    logic [WB_LOG-1:0] boff;
    logic              bit_err, word_err, hit;
    logic              is_bit_op, is_word_op;
    t_word             rd_word, srch_word, bitm, word_fn;
    logic              wr_en;
    t_word             wr_data;

    assign pos      = r_bi[BIDX_W-1:WB_LOG];
    assign boff     = r_bi[WB_LOG-1:0];
    assign lw       = last_word(r_len);
    assign bit_err  = LEN_W'(r_bi) >= r_len;
    assign word_err = r_wi > lw;
    assign bitm     = t_word'(1) << boff;
    assign n_len    = sat_len(i_cfg_wdata);

    assign is_bit_op  = (r_op == OP_TEST) || (r_op == OP_TEST_SET) ||
                        (r_op == OP_TEST_CLEAR);
    assign is_word_op = (r_op == OP_OR) || (r_op == OP_AND) || (r_op == OP_MINUS) ||
                        (r_op == OP_OR_NOT) || (r_op == OP_READ_WORD);

    // one read/write port; sweeps walk r_k
    assign rd_idx  = is_word_op ? r_wi : (is_bit_op ? pos : r_k);
    assign rd_word = r_words[rd_idx];

    // first search word ignores bits below the start position
    assign srch_word = rd_word & (r_first ? (t_word'('1) << boff) : t_word'('1));
    assign hit       = (srch_word != '0);

    assign o_sts.sweep = ((r_op == OP_NEXT_SET) && !bit_err) || (r_op == OP_COUNT) ||
                         (r_op == OP_ALL_CLEAR) || (r_op == OP_SET_ALL) ||
                         (r_op == OP_CLEAR_ALL) || (r_op == OP_COMPLEMENT);
    assign o_sts.done  = (r_k == lw) || ((r_op == OP_NEXT_SET) && hit);

    always_comb begin
        case (r_op)
            OP_OR:    word_fn = rd_word | r_opw;
            OP_AND:   word_fn = rd_word & r_opw;
            OP_MINUS: word_fn = rd_word & ~r_opw;
            OP_OR_NOT: word_fn = rd_word | ~r_opw;
            default:  word_fn = rd_word;
        endcase
    end

    always_comb begin
        n_k     = r_k;
        n_first = r_first;
        n_old   = r_old;
        n_found = r_found;
        n_fidx  = r_fidx;
        n_cnt   = r_cnt;
        n_allc  = r_allc;
        n_wout  = r_wout;
        n_err   = r_err;
        wr_en   = 1'b0;
        wr_data = rd_word;
        if (i_cmd.start) begin
            n_old   = 1'b0;
            n_found = 1'b0;
            n_fidx  = '0;
            n_cnt   = '0;
            n_allc  = (r_op == OP_ALL_CLEAR);
            n_wout  = '0;
            n_err   = 1'b0;
            n_first = 1'b1;
            n_k     = (r_op == OP_NEXT_SET) ? pos : '0;
            case (r_op) inside
                OP_TEST, OP_TEST_SET, OP_TEST_CLEAR: begin
                    n_err = bit_err;
                    if (!bit_err) begin
                        n_old   = rd_word[boff];
                        wr_en   = (r_op != OP_TEST);
                        wr_data = (r_op == OP_TEST_SET) ? (rd_word | bitm)
                                                        : (rd_word & ~bitm);
                    end
                end
                OP_NEXT_SET: n_err = bit_err;
                OP_OR, OP_AND, OP_MINUS, OP_OR_NOT, OP_READ_WORD: begin
                    n_err = word_err;
                    if (!word_err) begin
                        wr_data = word_fn & word_mask(r_len, r_wi);
                        wr_en   = (r_op != OP_READ_WORD);
                        n_wout  = wr_data;
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.step) begin
            n_k     = r_k + WIDX_W'(1);
            n_first = 1'b0;
            case (r_op)
                OP_NEXT_SET: begin
                    if (hit) begin
                        n_found = 1'b1;
                        n_fidx  = {r_k, low_bit(srch_word)};
                    end
                end
                OP_COUNT:     n_cnt = r_cnt + CNT_W'(pop_word(rd_word));
                OP_ALL_CLEAR: begin
                    if (rd_word != '0) begin
                        n_allc = 1'b0;
                    end
                end
                OP_SET_ALL: begin
                    wr_en   = 1'b1;
                    wr_data = word_mask(r_len, r_k);
                end
                OP_CLEAR_ALL: begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
                OP_COMPLEMENT: begin
                    wr_en   = 1'b1;
                    wr_data = ~rd_word & word_mask(r_len, r_k);
                end
                default: ;
            endcase
        end
    end

    // store, length and sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_WORDS; k++) begin
                r_words[k] <= '0;
            end
            r_len <= LEN_W'(MAX_BITS);
            r_k   <= '0;
        end else begin
            r_k <= n_k;
            if (i_cfg_we) begin
                r_len <= n_len;
                for (int k = 0; k < MAX_WORDS; k++) begin
                    r_words[k] <= r_words[k] & word_mask(n_len, WIDX_W'(k));
                end
            end else if (wr_en) begin
                r_words[rd_idx] <= wr_data;
            end
        end
    end

    // input capture, result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_opcode'(i_opcode);
            r_bi  <= i_bit_index;
            r_wi  <= i_word_index;
            r_opw <= i_operand_word;
        end
        r_first <= n_first;
        r_old   <= n_old;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_cnt   <= n_cnt;
        r_allc  <= n_allc;
        r_wout  <= n_wout;
        r_err   <= n_err;
        if (i_cmd.emit) begin
            o_old_bit     <= r_old;
            o_found       <= r_found;
            o_found_index <= r_fidx;
            o_bit_count   <= r_cnt;
            o_all_clear   <= r_allc;
            o_word_out    <= r_wout;
            o_index_error <= r_err;
        end
    end

    `BVE_ASSERT(a_len_range, r_len != '0 && r_len <= LEN_W'(MAX_BITS),
        "length register out of range")
    `BVE_ASSERT(a_tail_zero, (r_words[r_k] & ~word_mask(r_len, r_k)) == '0,
        "stored bit above length is set")
    `BVE_ASSERT_NEXT(a_set_all_word, i_cmd.step && r_op == OP_SET_ALL && !i_cfg_we,
        r_words[$past(r_k)] == word_mask(r_len, $past(r_k)),
        "set-all wrote wrong word")

endmodule
